// File: sv/sorted_key_accumulator_table_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted key accumulator table: assertion macros
// Shared concurrent assertion forms, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_ACCUMULATOR_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_ACCUMULATOR_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define SKAT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`define SKAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SKAT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define SKAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/skat_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key accumulator table: package
// Types, codes and fixed widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skat_pkg;

	localparam int TOTAL_W  = 32;
	localparam int COUNT_W  = 16;
	localparam int AMOUNT_W = 16;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACC  = 2'd0,
		ST_INS  = 2'd1,
		ST_FULL = 2'd2,
		ST_OOR  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_DATA,
		S_SRCH,
		S_CMP,
		S_SHIFT,
		S_DRAIN,
		S_INSERT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_pos;
		logic rd_mid;
		logic lo_up;
		logic hi_dn;
		logic sh_init;
		logic sh_step;
		logic acc;
		logic ins;
		logic emit_read;
		logic emit_oor;
		logic emit_full;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic pos_ok;
		logic lo_lt_hi;
		logic full;
		logic need_shift;
		logic key_eq;
		logic key_gt;
		logic sh_done;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/skat_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key accumulator table: controller
// Sequences the read, search, shift and insert steps of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skat_ctrl import skat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.is_read) begin
					state_nxt = st.pos_ok ? S_RD_DATA : S_IDLE;
				end else begin
					state_nxt = S_SRCH;
				end
			end
			S_RD_DATA: state_nxt = S_IDLE;
			S_SRCH: begin
				priority if (st.lo_lt_hi) begin
					state_nxt = S_CMP;
				end else if (st.full) begin
					state_nxt = S_IDLE;
				end else if (st.need_shift) begin
					state_nxt = S_SHIFT;
				end else begin
					state_nxt = S_INSERT;
				end
			end
			S_CMP: begin
				state_nxt = st.key_eq ? S_IDLE : S_SRCH;
			end
			S_SHIFT: begin
				if (st.sh_done) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN:  state_nxt = S_INSERT;
			S_INSERT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_DISPATCH: begin
				if (st.is_read) begin
					cmd.rd_pos   = st.pos_ok;
					cmd.emit_oor = !st.pos_ok;
				end
			end
			S_RD_DATA: cmd.emit_read = 1'b1;
			S_SRCH: begin
				priority if (st.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
				end else if (st.full) begin
					cmd.emit_full = 1'b1;
				end else begin
					cmd.sh_init = st.need_shift;
				end
			end
			S_CMP: begin
				priority if (st.key_eq) begin
					cmd.acc = 1'b1;
				end else if (st.key_gt) begin
					cmd.lo_up = 1'b1;
				end else begin
					cmd.hi_dn = 1'b1;
				end
			end
			S_SHIFT:  cmd.sh_step = 1'b1;
			S_DRAIN:  cmd = '0;
			S_INSERT: cmd.ins = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/skat_dp.sv
// ----------------------------------------------------------------------------
// Sorted key accumulator table: datapath
// Entry memory, search bounds, shift pointer, occupancy and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_accumulator_table_core_macros.svh"

module skat_dp import skat_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 16,
	parameter int AW          = 6,
	parameter int OW          = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic                req_type,
	input  logic [KEY_BITS-1:0] key,
	input  logic [AMOUNT_W-1:0] amount,
	input  logic [AW-1:0]       position,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [AW-1:0]       entry_position,
	output logic [KEY_BITS-1:0] entry_key,
	output logic [TOTAL_W-1:0]  entry_total,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [OW-1:0]       entries_used
);

	logic [KEY_BITS-1:0] key_mem   [TABLE_DEPTH];
	logic [TOTAL_W-1:0]  total_mem [TABLE_DEPTH];
	logic [COUNT_W-1:0]  count_mem [TABLE_DEPTH];

	logic                req_type_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AMOUNT_W-1:0] amount_q;
	logic [AW-1:0]       pos_q;
	logic [OW-1:0]       lo_q;
	logic [OW-1:0]       hi_q;
	logic [AW-1:0]       mid_q;
	logic [AW-1:0]       sh_q;
	logic [OW-1:0]       occ_q;
	logic                wr_pend_q;
	logic [AW-1:0]       wr_addr_q;

	logic [KEY_BITS-1:0] rd_key_q;
	logic [TOTAL_W-1:0]  rd_total_q;
	logic [COUNT_W-1:0]  rd_count_q;

	logic                done_q;
	status_t             status_q;
	logic [AW-1:0]       pos_out_q;
	logic [KEY_BITS-1:0] key_out_q;
	logic [TOTAL_W-1:0]  total_out_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic [OW-1:0]       used_out_q;

	logic [OW:0]         mid_sum;
	logic [AW-1:0]       mid_nxt;
	logic [OW-1:0]       occ_m1;
	logic [TOTAL_W:0]    tot_sum;
	logic [TOTAL_W-1:0]  acc_total;
	logic [COUNT_W-1:0]  acc_count;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_key;
	logic [TOTAL_W-1:0]  wr_total;
	logic [COUNT_W-1:0]  wr_count;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_nxt   = mid_sum[AW:1];
	assign occ_m1    = occ_q - OW'(1);
	assign tot_sum   = {1'b0, rd_total_q} + (TOTAL_W+1)'(amount_q);
	assign acc_total = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
	assign acc_count = (rd_count_q == '1) ? rd_count_q : rd_count_q + COUNT_W'(1);

	always_comb begin
		st.is_read    = req_type_q;
		st.pos_ok     = (OW'(pos_q) < occ_q);
		st.lo_lt_hi   = (lo_q < hi_q);
		st.full       = (occ_q == OW'(TABLE_DEPTH));
		st.need_shift = (occ_q > lo_q);
		st.key_eq     = (key_q == rd_key_q);
		st.key_gt     = (key_q > rd_key_q);
		st.sh_done    = (OW'(sh_q) == lo_q);
	end

	always_comb begin
		rd_en   = cmd.rd_pos | cmd.rd_mid | cmd.sh_step;
		rd_addr = sh_q;
		priority if (cmd.rd_pos) begin
			rd_addr = pos_q;
		end else if (cmd.rd_mid) begin
			rd_addr = mid_nxt;
		end
	end

	always_comb begin
		wr_en    = wr_pend_q | cmd.acc | cmd.ins;
		wr_addr  = wr_addr_q;
		wr_key   = rd_key_q;
		wr_total = rd_total_q;
		wr_count = rd_count_q;
		priority if (wr_pend_q) begin
			wr_addr = wr_addr_q;
		end else if (cmd.acc) begin
			wr_addr  = mid_q;
			wr_total = acc_total;
			wr_count = acc_count;
		end else if (cmd.ins) begin
			wr_addr  = lo_q[AW-1:0];
			wr_key   = key_q;
			wr_total = TOTAL_W'(amount_q);
			wr_count = COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			total_mem[wr_addr] <= wr_total;
			count_mem[wr_addr] <= wr_count;
		end
		if (rd_en) begin
			rd_key_q   <= key_mem[rd_addr];
			rd_total_q <= total_mem[rd_addr];
			rd_count_q <= count_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			key_q      <= key;
			amount_q   <= amount;
			pos_q      <= position;
		end
		priority if (cmd.load) begin
			lo_q <= '0;
			hi_q <= occ_q;
		end else if (cmd.lo_up) begin
			lo_q <= OW'(mid_q) + OW'(1);
		end else if (cmd.hi_dn) begin
			hi_q <= OW'(mid_q);
		end
		if (cmd.rd_mid) begin
			mid_q <= mid_nxt;
		end
		priority if (cmd.sh_init) begin
			sh_q <= occ_m1[AW-1:0];
		end else if (cmd.sh_step) begin
			sh_q <= sh_q - AW'(1);
		end
		if (cmd.sh_step) begin
			wr_addr_q <= sh_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			wr_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			wr_pend_q <= cmd.sh_step;
			done_q    <= cmd.emit_read | cmd.emit_oor | cmd.emit_full | cmd.acc | cmd.ins;
			if (cmd.ins) begin
				occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		used_out_q <= cmd.ins ? occ_q + OW'(1) : occ_q;
		priority if (cmd.emit_read) begin
			status_q    <= ST_ACC;
			pos_out_q   <= pos_q;
			key_out_q   <= rd_key_q;
			total_out_q <= rd_total_q;
			cnt_out_q   <= rd_count_q;
		end else if (cmd.emit_oor) begin
			status_q    <= ST_OOR;
			pos_out_q   <= pos_q;
			key_out_q   <= '0;
			total_out_q <= '0;
			cnt_out_q   <= '0;
		end else if (cmd.emit_full) begin
			status_q    <= ST_FULL;
			pos_out_q   <= '0;
			key_out_q   <= key_q;
			total_out_q <= '0;
			cnt_out_q   <= '0;
		end else if (cmd.acc) begin
			status_q    <= ST_ACC;
			pos_out_q   <= mid_q;
			key_out_q   <= rd_key_q;
			total_out_q <= acc_total;
			cnt_out_q   <= acc_count;
		end else if (cmd.ins) begin
			status_q    <= ST_INS;
			pos_out_q   <= lo_q[AW-1:0];
			key_out_q   <= key_q;
			total_out_q <= TOTAL_W'(amount_q);
			cnt_out_q   <= COUNT_W'(1);
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign entry_position = pos_out_q;
	assign entry_key      = key_out_q;
	assign entry_total    = total_out_q;
	assign entry_count    = cnt_out_q;
	assign entries_used   = used_out_q;

	`SKAT_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OW'(TABLE_DEPTH), "occupancy beyond depth")
	`SKAT_ASSERT_NEXT(a_ins_grows, clk, arst_n, cmd.ins, occ_q == $past(occ_q) + OW'(1), "insert lost")
	`SKAT_ASSERT_NEXT(a_occ_hold, clk, arst_n, !cmd.ins, $stable(occ_q), "occupancy moved")
	`SKAT_ASSERT_IMP(a_no_clash, clk, arst_n, wr_pend_q, !cmd.acc && !cmd.ins, "write port clash")
	`SKAT_ASSERT_IMP(a_ins_cnt, clk, arst_n, done_q && (status_q == ST_INS), cnt_out_q == COUNT_W'(1), "bad insert count")

endmodule

`default_nettype wire

// File: sv/sorted_key_accumulator_table_core.sv
// ----------------------------------------------------------------------------
// Sorted key accumulator table
// Table kept in ascending key order with per-key saturating totals and counts.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Word
//  request   start, taken when !busy req_type, key, amount, position
//  result    done, one-cycle strobe  status, entry_position, entry_key,
//                                    entry_total, entry_count, entries_used
//
// A read passes through dispatch and a data-read state before done; an
// out-of-range read ends at dispatch. Each binary search step of an update
// spends a search and a compare state, as each probe waits for the registered
// memory read; an insert then moves one entry per cycle through the single
// write port, followed by a drain and an insert state.
// Reset empties the table at once; entry contents are not cleared.
// Results cannot be stalled; a new request may start in the cycle of done.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_accumulator_table_core import skat_pkg::*; #(
	parameter  int TABLE_DEPTH = 64,
	parameter  int KEY_BITS    = 16,
	localparam int AW          = $clog2(TABLE_DEPTH),
	localparam int OW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                req_type,
	input  logic [KEY_BITS-1:0] key,
	input  logic [AMOUNT_W-1:0] amount,
	input  logic [AW-1:0]       position,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [AW-1:0]       entry_position,
	output logic [KEY_BITS-1:0] entry_key,
	output logic [TOTAL_W-1:0]  entry_total,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [OW-1:0]       entries_used
);

	cmd_t  cmd;
	stat_t st;

	skat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	skat_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.AW          (AW),
		.OW          (OW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.req_type       (req_type),
		.key            (key),
		.amount         (amount),
		.position       (position),
		.done           (done),
		.status         (status),
		.entry_position (entry_position),
		.entry_key      (entry_key),
		.entry_total    (entry_total),
		.entry_count    (entry_count),
		.entries_used   (entries_used)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted key accumulator table: testbench
// Drives update and read words through the start/busy handshake and checks
// every result word against an independent model of the sorted table. A
// directed opening covers empty, front, middle and end inserts, hits and
// out-of-range reads. A run of maximum-amount hits on one key builds up its
// total and count. A random phase then fills the table and keeps it full,
// so that inserts are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import skat_pkg::*;

	localparam int DEPTH          = 64;
	localparam int KEY_W          = 16;
	localparam int POS_W          = 6;
	localparam int USED_W         = 7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PRINT_LIMIT    = 50;
	localparam int REPEAT_HITS    = 40;
	localparam int RANDOM_ITEMS   = 1300;
	localparam logic REQ_UPDATE   = 1'b0;
	localparam logic REQ_READ     = 1'b1;

	typedef struct {
		logic                rd;
		logic [KEY_W-1:0]    k;
		logic [AMOUNT_W-1:0] amt;
		logic [POS_W-1:0]    pos;
		int unsigned         gap;
		bit                  drain;
	} request_t;

	typedef struct {
		status_t             st;
		logic [POS_W-1:0]    pos;
		logic [KEY_W-1:0]    k;
		logic [TOTAL_W-1:0]  total;
		logic [COUNT_W-1:0]  count;
		logic [USED_W-1:0]   used;
	} entry_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                req_type = 1'b0;
	logic [KEY_W-1:0]    key = '0;
	logic [AMOUNT_W-1:0] amount = '0;
	logic [POS_W-1:0]    position = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    entry_position;
	logic [KEY_W-1:0]    entry_key;
	logic [TOTAL_W-1:0]  entry_total;
	logic [COUNT_W-1:0]  entry_count;
	logic [USED_W-1:0]   entries_used;

	request_t    request_queue[$];
	entry_t      expected_entries[$];
	int          outstanding = 0;
	int unsigned gap_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned error_count = 0;

	logic [KEY_W-1:0]   stored_key[DEPTH];
	logic [TOTAL_W-1:0] stored_total[DEPTH];
	logic [COUNT_W-1:0] stored_count[DEPTH];
	int                 stored_used = 0;

	sorted_key_accumulator_table_core #(
		.TABLE_DEPTH(DEPTH),
		.KEY_BITS(KEY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.amount(amount),
		.position(position),
		.done(done),
		.status(status),
		.entry_position(entry_position),
		.entry_key(entry_key),
		.entry_total(entry_total),
		.entry_count(entry_count),
		.entries_used(entries_used)
	);

	always #5 clk = ~clk;

	task automatic report(string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Applies one request to the table copy and returns the word it should produce.
	function automatic entry_t track_request(logic rd, logic [KEY_W-1:0] k,
			logic [AMOUNT_W-1:0] amt, logic [POS_W-1:0] pos);
		int          lo;
		int          hi;
		int          mid;
		int          i;
		bit          hit;
		logic [32:0] sum;
		entry_t      res;
		res.st = ST_ACC;
		res.pos = '0;
		res.k = '0;
		res.total = '0;
		res.count = '0;
		if (rd == REQ_READ) begin
			res.pos = pos;
			if (int'(pos) < stored_used) begin
				res.k = stored_key[pos];
				res.total = stored_total[pos];
				res.count = stored_count[pos];
			end else begin
				res.st = ST_OOR;
			end
			res.used = USED_W'(stored_used);
			return res;
		end
		lo = 0;
		hi = stored_used;
		hit = 1'b0;
		mid = 0;
		while (lo < hi && !hit) begin
			mid = (lo + hi) >> 1;
			if (k > stored_key[mid]) begin
				lo = mid + 1;
			end else if (k < stored_key[mid]) begin
				hi = mid;
			end else begin
				hit = 1'b1;
			end
		end
		if (hit) begin
			sum = {1'b0, stored_total[mid]} + amt;
			stored_total[mid] = sum[32] ? '1 : sum[31:0];
			if (stored_count[mid] != '1) begin
				stored_count[mid] = stored_count[mid] + 1'b1;
			end
			res.pos = POS_W'(mid);
			res.k = stored_key[mid];
			res.total = stored_total[mid];
			res.count = stored_count[mid];
		end else if (stored_used >= DEPTH) begin
			res.st = ST_FULL;
			res.k = k;
		end else begin
			for (i = stored_used; i > lo; i--) begin
				stored_key[i] = stored_key[i-1];
				stored_total[i] = stored_total[i-1];
				stored_count[i] = stored_count[i-1];
			end
			stored_key[lo] = k;
			stored_total[lo] = TOTAL_W'(amt);
			stored_count[lo] = COUNT_W'(1);
			stored_used++;
			res.st = ST_INS;
			res.pos = POS_W'(lo);
			res.k = k;
			res.total = TOTAL_W'(amt);
			res.count = COUNT_W'(1);
		end
		res.used = USED_W'(stored_used);
		return res;
	endfunction

	function automatic request_t make_request(logic rd, logic [KEY_W-1:0] k,
			logic [AMOUNT_W-1:0] amt, logic [POS_W-1:0] pos, int unsigned gap, bit drain);
		request_t r;
		r.rd = rd;
		r.k = k;
		r.amt = amt;
		r.pos = pos;
		r.gap = gap;
		r.drain = drain;
		return r;
	endfunction

	task automatic queue_request(request_t r);
		request_queue.insert(request_queue.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		request_t head;
		if (!arst_n) begin
			start <= 1'b0;
			gap_count <= 0;
		end else if (!(start && busy)) begin
			if (request_queue.size() == 0) begin
				start <= 1'b0;
			end else if (gap_count < request_queue[0].gap) begin
				gap_count <= gap_count + 1;
				start <= 1'b0;
			end else if (request_queue[0].drain && (start || outstanding != 0)) begin
				start <= 1'b0;
			end else begin
				head = request_queue.pop_front();
				req_type <= head.rd;
				key <= head.k;
				amount <= head.amt;
				position <= head.pos;
				start <= 1'b1;
				gap_count <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		entry_t want;
		if (!arst_n) begin
			outstanding <= 0;
			quiet_cycles <= 0;
		end else begin
			if (done) begin
				if (expected_entries.size() == 0) begin
					report("result word with none expected");
				end else begin
					want = expected_entries.pop_front();
					check_field("status", 32'(status), 32'(want.st));
					check_field("entry_position", 32'(entry_position), 32'(want.pos));
					check_field("entry_key", 32'(entry_key), 32'(want.k));
					check_field("entry_total", entry_total, want.total);
					check_field("entry_count", 32'(entry_count), 32'(want.count));
					check_field("entries_used", 32'(entries_used), 32'(want.used));
				end
			end
			if (start && !busy) begin
				expected_entries.insert(expected_entries.size(),
					track_request(req_type, key, amount, position));
			end
			outstanding <= outstanding + int'(start && !busy) - int'(done);
			if (done || (start && !busy)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] key_pool[96];
		logic [KEY_W-1:0] k;
		logic [AMOUNT_W-1:0] amt;
		int unsigned gap;
		int n;
		for (n = 0; n < 96; n++) begin
			if (n < 12) begin
				key_pool[n] = KEY_W'(n);
			end else if (n < 24) begin
				key_pool[n] = 16'hFFFF - KEY_W'(n - 12);
			end else begin
				key_pool[n] = KEY_W'($urandom_range(0, 65535));
			end
		end

		// Opening: empty reads, inserts at the front, the end and the middle, then hits.
		queue_request(make_request(REQ_READ, 16'hFFFF, 16'hFFFF, 6'd0, 0, 0));
		queue_request(make_request(REQ_READ, 16'h0000, 16'h0000, 6'h3F, 2, 0));
		queue_request(make_request(REQ_UPDATE, 16'h8000, 16'hFFFF, 6'd0, 0, 0));
		queue_request(make_request(REQ_UPDATE, 16'h0000, 16'h0000, 6'h3F, 1, 0));
		queue_request(make_request(REQ_UPDATE, 16'hFFFF, 16'h0001, 6'h15, 0, 0));
		queue_request(make_request(REQ_UPDATE, 16'h4000, 16'h1234, 6'h2A, 4, 0));
		queue_request(make_request(REQ_UPDATE, 16'h8000, 16'hFFFF, 6'h3F, 0, 0));
		queue_request(make_request(REQ_UPDATE, 16'h0000, 16'h0000, 6'd0, 3, 0));
		queue_request(make_request(REQ_UPDATE, 16'hFFFF, 16'hFFFF, 6'd5, 0, 0));
		for (n = 0; n < 4; n++) begin
			queue_request(make_request(REQ_READ, 16'hFFFF, 16'hFFFF,
				POS_W'(n), n, 0));
		end
		queue_request(make_request(REQ_READ, 16'h5555, 16'hAAAA, 6'd4, 0, 0));
		queue_request(make_request(REQ_READ, 16'hAAAA, 16'h5555, 6'h3F, 1, 0));
		queue_request(make_request(REQ_READ, 16'h0000, 16'h0000, 6'h20, 0, 1));

		// Repeated maximum amounts on one key build up its total and count.
		for (n = 0; n < REPEAT_HITS; n++) begin
			queue_request(make_request(REQ_UPDATE, 16'h8000, 16'hFFFF,
				POS_W'($urandom_range(0, 63)), 0, 0));
		end
		queue_request(make_request(REQ_READ, 16'h0000, 16'h0000, 6'd2, 0, 1));

		// Random traffic: mostly updates on a limited key set, so the table fills,
		// then keeps taking hits while new keys are dropped.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			gap = ((n / 50) % 4 == 0) ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 9) < 3) begin
				queue_request(make_request(REQ_READ,
					KEY_W'($urandom_range(0, 65535)), AMOUNT_W'($urandom_range(0, 65535)),
					POS_W'($urandom_range(0, 63)), gap, (n % 300) == 299));
			end else begin
				if ($urandom_range(0, 4) == 0) begin
					k = KEY_W'($urandom_range(0, 65535));
				end else begin
					k = key_pool[$urandom_range(0, 95)];
				end
				case ($urandom_range(0, 19))
					0: amt = '0;
					1, 2: amt = '1;
					default: amt = AMOUNT_W'($urandom_range(0, 65535));
				endcase
				queue_request(make_request(REQ_UPDATE, k, amt,
					POS_W'($urandom_range(0, 63)), gap, (n % 300) == 299));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (request_queue.size() != 0 || start || outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
